>>> design/swsp_pkg.sv
// Shared types, constants and helpers for the shell word splitter.
package swsp_pkg;

    localparam int CHAR_W     = 8;
    localparam int PKT_RES    = 4;
    localparam int IDX_W      = $clog2(PKT_RES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = QPTR_W + 1;

    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_BTICK  = 8'h60;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_WORD_END = 2'd1,
        KIND_CMD_END  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'b001,
        MODE_SINGLE = 3'b010,
        MODE_DOUBLE = 3'b100
    } mode_t;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
        logic              unterm;
    } res_t;

    typedef struct packed {
        res_t [PKT_RES-1:0] res;
        logic [IDX_W-1:0]   last_idx;
    } pkt_t;

    function automatic res_t mk_res(kind_t k, logic [CHAR_W-1:0] c, logic u);
        res_t r;
        r.kind   = k;
        r.ch     = c;
        r.unterm = u;
        return r;
    endfunction

endpackage

>>> design/swsp_classify.sv
// Front end: accepts bytes, tracks quoting state and builds result packets.
module swsp_classify
    import swsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [CHAR_W-1:0] char_in,
    input  logic              last_char,
    output logic              pkt_valid,
    output pkt_t              pkt
);

    mode_t mode_reg;
    mode_t mode_next;
    logic  esc_reg;
    logic  esc_next;
    logic  wo_reg;
    logic  wo_next;
    logic [CNT_W-1:0] n;
    logic  is_blank;
    logic  dq_special;

    always_comb
    begin
        pkt        = '0;
        n          = '0;
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        wo_next    = wo_reg;
        is_blank   = (char_in == CH_SPACE) || (char_in inside {[CH_TAB:CH_CR]});
        dq_special = char_in inside {CH_DQUOTE, CH_BSLASH, CH_DOLLAR, CH_BTICK};

        if (esc_reg)
        begin
            esc_next = 1'b0;
            if (mode_reg == MODE_DOUBLE && !dq_special)
            begin
                pkt.res[n[IDX_W-1:0]] = mk_res(KIND_CHAR, CH_BSLASH, 1'b0);
                n = n + CNT_W'(1);
            end
            pkt.res[n[IDX_W-1:0]] = mk_res(KIND_CHAR, char_in, 1'b0);
            n = n + CNT_W'(1);
            wo_next = 1'b1;
        end
        else
        begin
            case (mode_reg)
                MODE_PLAIN:
                begin
                    if (char_in == CH_BSLASH && !last_char)
                    begin
                        esc_next = 1'b1;
                        wo_next  = 1'b1;
                    end
                    else if (char_in == CH_SQUOTE)
                    begin
                        mode_next = MODE_SINGLE;
                        wo_next   = 1'b1;
                    end
                    else if (char_in == CH_DQUOTE)
                    begin
                        mode_next = MODE_DOUBLE;
                        wo_next   = 1'b1;
                    end
                    else if (is_blank)
                    begin
                        if (wo_reg)
                        begin
                            pkt.res[n[IDX_W-1:0]] = mk_res(KIND_WORD_END, '0, 1'b0);
                            n = n + CNT_W'(1);
                            wo_next = 1'b0;
                        end
                    end
                    else
                    begin
                        pkt.res[n[IDX_W-1:0]] = mk_res(KIND_CHAR, char_in, 1'b0);
                        n = n + CNT_W'(1);
                        wo_next = 1'b1;
                    end
                end
                MODE_SINGLE:
                begin
                    if (char_in == CH_SQUOTE)
                    begin
                        mode_next = MODE_PLAIN;
                    end
                    else
                    begin
                        pkt.res[n[IDX_W-1:0]] = mk_res(KIND_CHAR, char_in, 1'b0);
                        n = n + CNT_W'(1);
                    end
                end
                default:
                begin
                    if (char_in == CH_BSLASH && !last_char)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (char_in == CH_DQUOTE)
                    begin
                        mode_next = MODE_PLAIN;
                    end
                    else
                    begin
                        pkt.res[n[IDX_W-1:0]] = mk_res(KIND_CHAR, char_in, 1'b0);
                        n = n + CNT_W'(1);
                    end
                end
            endcase
        end

        if (last_char)
        begin
            if (wo_next)
            begin
                pkt.res[n[IDX_W-1:0]] = mk_res(KIND_WORD_END, '0, 1'b0);
                n = n + CNT_W'(1);
            end
            pkt.res[n[IDX_W-1:0]] = mk_res(KIND_CMD_END, '0, mode_next != MODE_PLAIN);
            n = n + CNT_W'(1);
            mode_next = MODE_PLAIN;
            esc_next  = 1'b0;
            wo_next   = 1'b0;
        end

        pkt.last_idx = IDX_W'(n - CNT_W'(1));
    end

    assign pkt_valid = accept && (n != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
            esc_reg  <= 1'b0;
            wo_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            wo_reg   <= wo_next;
        end
    end

    a_esc_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> wo_reg)
        else $error("escape pending outside a word");

    a_cmd_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_char |=> mode_reg == MODE_PLAIN && !esc_reg && !wo_reg)
        else $error("state not cleared after command end");

endmodule

>>> design/swsp_queue.sv
// Short packet queue between the front end and the serialiser.
module swsp_queue
    import swsp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  pkt_t wr_pkt,
    output logic q_full,
    input  logic rd_en,
    output logic q_nonempty,
    output pkt_t rd_pkt
);

    pkt_t              store_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign q_full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_nonempty = (cnt_reg != '0);
    assign rd_pkt     = store_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_ptr_reg] <= wr_pkt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("queue write while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> q_nonempty)
        else $error("queue read while empty");

endmodule

>>> design/swsp_serialize.sv
// Back end: holds one packet and hands out its results one beat at a time.
module swsp_serialize
    import swsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_nonempty,
    input  pkt_t              q_pkt,
    output logic              q_rd,
    input  logic              pop,
    output logic              empty,
    output logic [1:0]        kind,
    output logic [CHAR_W-1:0] out_char,
    output logic              unterminated,
    output logic              last_result
);

    logic             cur_valid_reg;
    logic             cur_valid_next;
    pkt_t             cur_pkt_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             at_last;
    logic             take;
    res_t             cur_res;

    assign at_last = (idx_reg == cur_pkt_reg.last_idx);
    assign take    = !cur_valid_reg || (pop && at_last);
    assign q_rd    = take && q_nonempty;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (take)
        begin
            cur_valid_next = q_nonempty;
            idx_next       = '0;
        end
        else if (pop)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            cur_pkt_reg <= q_pkt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    assign cur_res      = cur_pkt_reg.res[idx_reg];
    assign empty        = !cur_valid_reg;
    assign kind         = cur_res.kind;
    assign out_char     = cur_res.ch;
    assign unterminated = cur_res.unterm;
    assign last_result  = at_last;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> idx_reg <= cur_pkt_reg.last_idx)
        else $error("result index beyond packet");

endmodule

>>> design/shell_word_splitter_core.sv
// Top level of the shell word splitter: front end, packet queue and serialiser.
// Path: a byte's results are written as one packet into the queue when the
// byte is accepted, then loaded into the result holding stage and offered.
// Throughput: one byte per cycle while full is low and each byte yields at
// most one result; a byte with n results is handed out one result per pop,
// and the four-packet queue absorbs such bursts before full rises.
// Reset: rst_n clears quoting state, the queue and the result holding stage.
module shell_word_splitter_core
    import swsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CHAR_W-1:0] char_in,
    input  logic              last_char,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        kind,
    output logic [CHAR_W-1:0] out_char,
    output logic              unterminated,
    output logic              last_result
);

    logic accept;
    logic pkt_valid;
    pkt_t pkt;
    logic q_full;
    logic q_rd;
    logic q_nonempty;
    pkt_t q_pkt;

    assign full   = q_full;
    assign accept = push && !q_full;

    swsp_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_in   (char_in),
        .last_char (last_char),
        .pkt_valid (pkt_valid),
        .pkt       (pkt)
    );

    swsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (pkt_valid),
        .wr_pkt     (pkt),
        .q_full     (q_full),
        .rd_en      (q_rd),
        .q_nonempty (q_nonempty),
        .rd_pkt     (q_pkt)
    );

    swsp_serialize u_serialize (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_nonempty   (q_nonempty),
        .q_pkt        (q_pkt),
        .q_rd         (q_rd),
        .pop          (pop),
        .empty        (empty),
        .kind         (kind),
        .out_char     (out_char),
        .unterminated (unterminated),
        .last_result  (last_result)
    );

endmodule
